>>> sv/uvsg_pkg.sv
// Shared constants and step coefficient tables of the UV sphere vertex generator.
package uvsg_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int MAX_DIVISIONS = 256;
    localparam int TRIG_STAGES   = 21;
    localparam int SIN_STEPS     = 5;
    localparam int COS_STEPS     = 6;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

    // Register indexes; the byte address of a register is four times its index.
    localparam logic [1:0] REG_RADIUS  = 2'd0;
    localparam logic [1:0] REG_SECTORS = 2'd1;
    localparam logic [1:0] REG_STACKS  = 2'd2;

    // Divisors of the sine series steps, innermost first.
    function automatic logic [7:0] sin_div(input int n);
        logic [7:0] k;
        case (n)
            0:       k = 8'd110;
            1:       k = 8'd72;
            2:       k = 8'd42;
            3:       k = 8'd20;
            default: k = 8'd6;
        endcase
        return k;
    endfunction

    // floor(2^32 / sin_div(n)).
    function automatic logic [31:0] sin_recip(input int n);
        logic [31:0] m;
        case (n)
            0:       m = 32'd39045157;
            1:       m = 32'd59652323;
            2:       m = 32'd102261126;
            3:       m = 32'd214748364;
            default: m = 32'd715827882;
        endcase
        return m;
    endfunction

    // Divisors of the cosine series steps, innermost first.
    function automatic logic [7:0] cos_div(input int n);
        logic [7:0] k;
        case (n)
            0:       k = 8'd132;
            1:       k = 8'd90;
            2:       k = 8'd56;
            3:       k = 8'd30;
            4:       k = 8'd12;
            default: k = 8'd2;
        endcase
        return k;
    endfunction

    // floor(2^32 / cos_div(n)).
    function automatic logic [31:0] cos_recip(input int n);
        logic [31:0] m;
        case (n)
            0:       m = 32'd32537631;
            1:       m = 32'd47721858;
            2:       m = 32'd76695844;
            3:       m = 32'd143165576;
            4:       m = 32'd357913941;
            default: m = 32'd2147483648;
        endcase
        return m;
    endfunction

endpackage

>>> sv/uv_sphere_vertex_generator.sv
// UV sphere vertex generator: grid point in, position, normal and texture coordinates out.
//
//  channel | direction | handshake                 | payload
//  s_      | in        | s_tvalid / s_tready       | s_tdata: stack_index, sector_index
//  m_      | out       | m_tvalid / m_tready       | m_tdata: pos, norm, tex
//  apb     | in        | psel / penable / pready   | sphere_radius, sector_count, stack_count
//
// One grid point enters per cycle while a stall at m_ does not back up the pipeline.
// The 43 stages are one input stage, 17 restoring-divider stages, the 21-stage sine/cosine
// unit and four output stages.
// Reset (aresetn low, synchronous) empties the pipeline and loads the register defaults.
// A stall at m_ holds every occupied stage with no empty stage ahead of it; empty stages
// keep loading, so bubbles are squeezed out.
module uv_sphere_vertex_generator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // stack_index[8:0], sector_index[17:9], zero[23:18]
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x[16:0], pos_y[33:17], pos_z[50:34], norm_x[66:51], norm_y[82:67],
    // norm_z[98:83], tex_s[115:99], tex_t[132:116], zero[135:133]
    output logic [135:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int NS        = 43;
    localparam int DIV_STEPS = 17;
    localparam int TRIG_LO   = 18;
    localparam int TRIG_HI   = TRIG_LO + uvsg_pkg::TRIG_STAGES - 1;

    function automatic logic [8:0] eff_count(input logic [8:0] c);
        logic [8:0] r;
        if (c == 9'd0) begin
            r = 9'd1;
        end else if (c > 9'(uvsg_pkg::MAX_DIVISIONS)) begin
            r = 9'(uvsg_pkg::MAX_DIVISIONS);
        end else begin
            r = c;
        end
        return r;
    endfunction

    // Divide by 2^sh, rounding half away from zero.
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int sh);
        logic [63:0] mag;
        mag = v[63] ? -v : v;
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(mag) : $signed(mag);
    endfunction

    // Configuration registers.
    logic [15:0] radius_reg;
    logic [8:0]  sectors_reg;
    logic [8:0]  stacks_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg  <= 16'd256;
            sectors_reg <= 9'd36;
            stacks_reg  <= 9'd18;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                uvsg_pkg::REG_RADIUS:  radius_reg  <= pwdata[15:0];
                uvsg_pkg::REG_SECTORS: sectors_reg <= pwdata[8:0];
                uvsg_pkg::REG_STACKS:  stacks_reg  <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            uvsg_pkg::REG_RADIUS:  prdata = {16'd0, radius_reg};
            uvsg_pkg::REG_SECTORS: prdata = {23'd0, sectors_reg};
            uvsg_pkg::REG_STACKS:  prdata = {23'd0, stacks_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // Stage control: a stage loads when it is empty or the stage after it loads.
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] stage_en;

    assign stage_en[NS-1] = !valid_reg[NS-1] || m_tready;
    genvar k, d;
    generate
        for (k = 0; k < NS - 1; k++) begin : g_en
            assign stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int s = 1; s < NS; s++) begin
                if (stage_en[s]) begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[NS-1];

    // Stage 0: saturate indices and form the three rounded-division numerators.
    logic [8:0]  secs;
    logic [8:0]  stks;
    logic [8:0]  stack_sat;
    logic [8:0]  sector_sat;
    logic [24:0] num_w [0:2];
    logic [8:0]  div_den [0:2];

    assign secs       = eff_count(sectors_reg);
    assign stks       = eff_count(stacks_reg);
    assign stack_sat  = (s_tdata[8:0] > stks) ? stks : s_tdata[8:0];
    assign sector_sat = (s_tdata[17:9] > secs) ? secs : s_tdata[17:9];
    assign num_w[0]   = {sector_sat, 16'd0} + 25'(secs[8:1]);
    assign num_w[1]   = 25'({stack_sat, 15'd0}) + 25'(stks[8:1]);
    assign num_w[2]   = {stack_sat, 16'd0} + 25'(stks[8:1]);
    assign div_den[0] = secs;
    assign div_den[1] = stks;
    assign div_den[2] = stks;

    // Restoring dividers, one quotient bit per stage; quotient bits shift into num.
    logic [8:0]  rem_reg [0:2][0:DIV_STEPS];
    logic [16:0] num_reg [0:2][0:DIV_STEPS];

    generate
        for (d = 0; d < 3; d++) begin : g_div
            always_ff @(posedge aclk) begin
                if (stage_en[0]) begin
                    rem_reg[d][0] <= {1'b0, num_w[d][24:17]};
                    num_reg[d][0] <= num_w[d][16:0];
                end
            end
            for (k = 1; k <= DIV_STEPS; k++) begin : g_bit
                logic [9:0] rr_w;
                logic       ge_w;
                assign rr_w = {rem_reg[d][k-1], num_reg[d][k-1][16]};
                assign ge_w = rr_w >= 10'(div_den[d]);
                always_ff @(posedge aclk) begin
                    if (stage_en[k]) begin
                        rem_reg[d][k] <= ge_w ? 9'(rr_w - 10'(div_den[d])) : rr_w[8:0];
                        num_reg[d][k] <= {num_reg[d][k-1][15:0], ge_w};
                    end
                end
            end
        end
    endgenerate

    // Phases in turns.
    logic [15:0] phase_v;
    logic [15:0] phase_u;
    assign phase_v = num_reg[0][DIV_STEPS][15:0];
    assign phase_u = 16'd16384 - num_reg[1][DIV_STEPS][15:0];

    logic signed [31:0] su_w, cu_w, sv_w, cv_w;

    uvsg_trig u_trig_u (
        .aclk     (aclk),
        .stage_en (stage_en[TRIG_HI:TRIG_LO]),
        .phase    (phase_u),
        .sin_q30  (su_w),
        .cos_q30  (cu_w)
    );

    uvsg_trig u_trig_v (
        .aclk     (aclk),
        .stage_en (stage_en[TRIG_HI:TRIG_LO]),
        .phase    (phase_v),
        .sin_q30  (sv_w),
        .cos_q30  (cv_w)
    );

    // Texture coordinates ride alongside the trig unit.
    logic [16:0] tex_s_reg [TRIG_LO:NS-1];
    logic [16:0] tex_t_reg [TRIG_LO:NS-1];

    always_ff @(posedge aclk) begin
        if (stage_en[TRIG_LO]) begin
            tex_s_reg[TRIG_LO] <= num_reg[0][DIV_STEPS];
            tex_t_reg[TRIG_LO] <= num_reg[2][DIV_STEPS];
        end
        for (int s = TRIG_LO + 1; s < NS; s++) begin
            if (stage_en[s]) begin
                tex_s_reg[s] <= tex_s_reg[s-1];
                tex_t_reg[s] <= tex_t_reg[s-1];
            end
        end
    end

    // Normal products, rounding, radius scaling and output registers.
    logic signed [63:0] ccv_reg, csv_reg;
    logic signed [31:0] su_reg;
    logic signed [31:0] n_reg    [0:2];
    logic signed [48:0] pr_reg   [0:2];
    logic signed [15:0] nn_reg   [0:2];
    logic [16:0]        pos_reg  [0:2];
    logic [15:0]        norm_reg [0:2];

    always_ff @(posedge aclk) begin
        if (stage_en[TRIG_HI+1]) begin
            ccv_reg <= 64'(cu_w) * 64'(cv_w);
            csv_reg <= 64'(cu_w) * 64'(sv_w);
            su_reg  <= su_w;
        end
        if (stage_en[TRIG_HI+2]) begin
            n_reg[0] <= 32'(round_shift(ccv_reg, 30));
            n_reg[1] <= 32'(round_shift(csv_reg, 30));
            n_reg[2] <= su_reg;
        end
    end

    generate
        for (k = 0; k < 3; k++) begin : g_out
            logic signed [63:0] nr_w;
            assign nr_w = round_shift(64'(n_reg[k]), 15);
            always_ff @(posedge aclk) begin
                if (stage_en[TRIG_HI+3]) begin
                    pr_reg[k] <= $signed({33'd0, radius_reg}) * 49'(n_reg[k]);
                    if (nr_w > 64'sd32767) begin
                        nn_reg[k] <= 16'sd32767;
                    end else if (nr_w < -64'sd32767) begin
                        nn_reg[k] <= -16'sd32767;
                    end else begin
                        nn_reg[k] <= 16'(nr_w);
                    end
                end
                if (stage_en[TRIG_HI+4]) begin
                    pos_reg[k]  <= 17'(round_shift(64'(pr_reg[k]), 30));
                    norm_reg[k] <= nn_reg[k];
                end
            end
        end
    endgenerate

    assign m_tdata = {3'b000, tex_t_reg[NS-1], tex_s_reg[NS-1],
                      norm_reg[2], norm_reg[1], norm_reg[0],
                      pos_reg[2], pos_reg[1], pos_reg[0]};

    a_tex_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[115:99] <= 17'd65536 && m_tdata[132:116] <= 17'd65536))
        else $error("texture coordinate above 1.0");

    a_norm_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[66:51] != 16'h8000 && m_tdata[82:67] != 16'h8000 &&
                      m_tdata[98:83] != 16'h8000))
        else $error("normal component outside clamp range");

    a_zero_radius: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && radius_reg == 16'd0) |-> (m_tdata[50:0] == 51'd0))
        else $error("nonzero position with zero radius");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (valid_reg[0] && m_tvalid && !m_tready))
        else $error("input stalled while pipeline can advance");

endmodule

>>> sv/uvsg_trig.sv
// Pipelined sine and cosine of a 16-bit turn phase, Q30 results.
module uvsg_trig (
    input  logic                                 aclk,
    input  logic [uvsg_pkg::TRIG_STAGES-1:0]     stage_en,  // bit t-1 loads stage t
    input  logic [uvsg_pkg::ANGLE_BITS-1:0]      phase,
    output logic signed [31:0]                   sin_q30,
    output logic signed [31:0]                   cos_q30
);

    localparam int NT = uvsg_pkg::TRIG_STAGES;

    logic [1:0]  quad_reg [1:NT-1];
    logic [44:0] pa_reg;
    logic [30:0] a_reg    [2:17];
    logic [31:0] a2_reg   [2:17];

    logic [31:0] sin_v_reg  [0:uvsg_pkg::SIN_STEPS-1];
    logic [31:0] sin_vb_reg [0:uvsg_pkg::SIN_STEPS-1];
    logic [31:0] sin_q0_reg [0:uvsg_pkg::SIN_STEPS-1];
    logic [30:0] sin_t_reg  [0:uvsg_pkg::SIN_STEPS-1];
    logic [31:0] cos_v_reg  [0:uvsg_pkg::COS_STEPS-1];
    logic [31:0] cos_vb_reg [0:uvsg_pkg::COS_STEPS-1];
    logic [31:0] cos_q0_reg [0:uvsg_pkg::COS_STEPS-1];
    logic [30:0] cos_t_reg  [0:uvsg_pkg::COS_STEPS-1];

    logic [30:0] sin_sp_reg;
    logic [30:0] sin_s_reg;
    logic [30:0] sin_d_reg;
    logic signed [31:0] sin_out_reg;
    logic signed [31:0] cos_out_reg;

    logic [44:0] pa_next;
    logic [30:0] a_w;
    logic [61:0] sq_w;
    logic [61:0] sp_w;

    assign pa_next = 45'(phase[13:0]) * 45'(uvsg_pkg::HALF_PI_Q30);
    assign a_w     = pa_reg[44:14];
    assign sq_w    = 62'(a_w) * 62'(a_w);
    assign sp_w    = 62'(a_reg[17]) * 62'(sin_t_reg[uvsg_pkg::SIN_STEPS-1]);

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            pa_reg      <= pa_next;
            quad_reg[1] <= phase[15:14];
        end
        if (stage_en[1]) begin
            a_reg[2]  <= a_w;
            a2_reg[2] <= sq_w[61:30];
        end
    end

    genvar g;
    generate
        for (g = 2; g < NT; g++) begin : g_quad
            always_ff @(posedge aclk) begin
                if (stage_en[g-1]) begin
                    quad_reg[g] <= quad_reg[g-1];
                end
            end
        end
        for (g = 3; g <= 17; g++) begin : g_angle
            always_ff @(posedge aclk) begin
                if (stage_en[g-1]) begin
                    a_reg[g]  <= a_reg[g-1];
                    a2_reg[g] <= a2_reg[g-1];
                end
            end
        end

        // Each series step is multiply, reciprocal multiply, then correct and subtract.
        for (g = 0; g < uvsg_pkg::SIN_STEPS; g++) begin : g_sin
            localparam int TA = 3 + 3 * g;
            localparam logic [7:0]  K = uvsg_pkg::sin_div(g);
            localparam logic [31:0] M = uvsg_pkg::sin_recip(g);
            logic [30:0] t_in;
            logic [62:0] pa_w;
            logic [63:0] pb_w;
            logic [33:0] rem_w;
            logic [32:0] q_w;
            if (g == 0) begin : g_first
                assign t_in = uvsg_pkg::Q30_ONE;
            end else begin : g_rest
                assign t_in = sin_t_reg[g-1];
            end
            assign pa_w  = 63'(a2_reg[TA-1]) * 63'(t_in);
            assign pb_w  = 64'(sin_v_reg[g]) * 64'(M);
            assign rem_w = 34'(sin_vb_reg[g]) - 34'(34'(sin_q0_reg[g]) * 34'(K));
            assign q_w   = 33'(sin_q0_reg[g]) + 33'(rem_w >= 34'(K));
            always_ff @(posedge aclk) begin
                if (stage_en[TA-1]) begin
                    sin_v_reg[g] <= pa_w[61:30];
                end
                if (stage_en[TA]) begin
                    sin_vb_reg[g] <= sin_v_reg[g];
                    sin_q0_reg[g] <= pb_w[63:32];
                end
                if (stage_en[TA+1]) begin
                    sin_t_reg[g] <= (q_w >= 33'(uvsg_pkg::Q30_ONE)) ? 31'd0 :
                                    31'(33'(uvsg_pkg::Q30_ONE) - q_w);
                end
            end
        end

        for (g = 0; g < uvsg_pkg::COS_STEPS; g++) begin : g_cos
            localparam int TA = 3 + 3 * g;
            localparam logic [7:0]  K = uvsg_pkg::cos_div(g);
            localparam logic [31:0] M = uvsg_pkg::cos_recip(g);
            logic [30:0] t_in;
            logic [62:0] pa_w;
            logic [63:0] pb_w;
            logic [33:0] rem_w;
            logic [32:0] q_w;
            if (g == 0) begin : g_first
                assign t_in = uvsg_pkg::Q30_ONE;
            end else begin : g_rest
                assign t_in = cos_t_reg[g-1];
            end
            assign pa_w  = 63'(a2_reg[TA-1]) * 63'(t_in);
            assign pb_w  = 64'(cos_v_reg[g]) * 64'(M);
            assign rem_w = 34'(cos_vb_reg[g]) - 34'(34'(cos_q0_reg[g]) * 34'(K));
            assign q_w   = 33'(cos_q0_reg[g]) + 33'(rem_w >= 34'(K));
            always_ff @(posedge aclk) begin
                if (stage_en[TA-1]) begin
                    cos_v_reg[g] <= pa_w[61:30];
                end
                if (stage_en[TA]) begin
                    cos_vb_reg[g] <= cos_v_reg[g];
                    cos_q0_reg[g] <= pb_w[63:32];
                end
                if (stage_en[TA+1]) begin
                    cos_t_reg[g] <= (q_w >= 33'(uvsg_pkg::Q30_ONE)) ? 31'd0 :
                                    31'(33'(uvsg_pkg::Q30_ONE) - q_w);
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (stage_en[17]) begin
            sin_sp_reg <= sp_w[60:30];
        end
        if (stage_en[18]) begin
            sin_s_reg <= (sin_sp_reg > uvsg_pkg::Q30_ONE) ? uvsg_pkg::Q30_ONE : sin_sp_reg;
        end
        if (stage_en[19]) begin
            sin_d_reg <= sin_s_reg;
        end
        if (stage_en[20]) begin
            case (quad_reg[20])
                2'd0: begin
                    sin_out_reg <= 32'(sin_d_reg);
                    cos_out_reg <= 32'(cos_t_reg[uvsg_pkg::COS_STEPS-1]);
                end
                2'd1: begin
                    sin_out_reg <= 32'(cos_t_reg[uvsg_pkg::COS_STEPS-1]);
                    cos_out_reg <= -32'(sin_d_reg);
                end
                2'd2: begin
                    sin_out_reg <= -32'(sin_d_reg);
                    cos_out_reg <= -32'(cos_t_reg[uvsg_pkg::COS_STEPS-1]);
                end
                default: begin
                    sin_out_reg <= -32'(cos_t_reg[uvsg_pkg::COS_STEPS-1]);
                    cos_out_reg <= 32'(sin_d_reg);
                end
            endcase
        end
    end

    assign sin_q30 = sin_out_reg;
    assign cos_q30 = cos_out_reg;

endmodule

>>> tb/sv/tb_uv_sphere_vertex_generator.sv
// Self-checking testbench of the UV sphere vertex generator with random flow control.
module tb_uv_sphere_vertex_generator;

    typedef struct packed {
        logic [16:0] tex_t;
        logic [16:0] tex_s;
        logic [15:0] norm_z;
        logic [15:0] norm_y;
        logic [15:0] norm_x;
        logic [16:0] pos_z;
        logic [16:0] pos_y;
        logic [16:0] pos_x;
    } vertex_t;

    localparam longint     UNIT_Q30    = 64'sd1 << 30;
    localparam int         CYCLE_LIMIT = 400000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    uv_sphere_vertex_generator dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the register file.
    logic [15:0] radius_q88 = 16'd256;
    logic [8:0]  sectors_reg = 9'd36;
    logic [8:0]  stacks_reg = 9'd18;

    logic [17:0] grid_points[$];
    vertex_t     vertices_due[$];
    bit          failed = 0;
    bit          s_fire = 0;
    bit          m_fire = 0;
    bit          s_lazy = 0;
    bit          m_lazy = 0;
    int          s_gap = 0;
    int          m_stall = 0;
    int          cycles = 0;

    function automatic longint unit_clamp(input longint t);
        if (t < 0) return 0;
        if (t > UNIT_Q30) return UNIT_Q30;
        return t;
    endfunction

    function automatic longint shift_round(input longint v, input int sh);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 << (sh - 1))) >>> sh;
        return (v < 0) ? -m : m;
    endfunction

    // Sine and cosine in Q30 of a phase given in turns with 32 fraction bits.
    task automatic sin_cos(input logic [31:0] phase, output longint sn, output longint cs);
        longint sdiv[5];
        longint cdiv[6];
        longint a, a2, t, s, c;
        sdiv = '{110, 72, 42, 20, 6};
        cdiv = '{132, 90, 56, 30, 12, 2};
        a = longint'((64'(phase[29:0]) * 64'd1686629713) >> 30);
        a2 = (a * a) >>> 30;
        t = UNIT_Q30;
        for (int n = 0; n < 5; n++) t = unit_clamp(UNIT_Q30 - ((a2 * t) >>> 30) / sdiv[n]);
        s = unit_clamp((a * t) >>> 30);
        t = UNIT_Q30;
        for (int n = 0; n < 6; n++) t = unit_clamp(UNIT_Q30 - ((a2 * t) >>> 30) / cdiv[n]);
        c = t;
        case (phase[31:30])
            2'd0: begin sn = s;  cs = c;  end
            2'd1: begin sn = c;  cs = -s; end
            2'd2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endtask

    task automatic vertex_of(input logic [8:0] stack, input logic [8:0] sector,
                             output vertex_t vx);
        longint secs, stks, i, j, pv, pu, su, cu, sv, cv, p;
        longint nrm[3];
        secs = (sectors_reg == 0) ? 1 : (sectors_reg > 256) ? 256 : sectors_reg;
        stks = (stacks_reg == 0) ? 1 : (stacks_reg > 256) ? 256 : stacks_reg;
        i = (stack > stks) ? stks : stack;
        j = (sector > secs) ? secs : sector;
        pv = (((j << 16) + secs / 2) / secs) & 16'hFFFF;
        pu = (16384 - ((i << 15) + stks / 2) / stks) & 16'hFFFF;
        sin_cos(32'(pu << 16), su, cu);
        sin_cos(32'(pv << 16), sv, cv);
        nrm[0] = shift_round(cu * cv, 30);
        nrm[1] = shift_round(cu * sv, 30);
        nrm[2] = su;
        vx.pos_x = 17'(shift_round(longint'(radius_q88) * nrm[0], 30));
        vx.pos_y = 17'(shift_round(longint'(radius_q88) * nrm[1], 30));
        vx.pos_z = 17'(shift_round(longint'(radius_q88) * nrm[2], 30));
        p = shift_round(nrm[0], 15); p = (p > 32767) ? 32767 : (p < -32767) ? -32767 : p;
        vx.norm_x = 16'(p);
        p = shift_round(nrm[1], 15); p = (p > 32767) ? 32767 : (p < -32767) ? -32767 : p;
        vx.norm_y = 16'(p);
        p = shift_round(nrm[2], 15); p = (p > 32767) ? 32767 : (p < -32767) ? -32767 : p;
        vx.norm_z = 16'(p);
        vx.tex_s = 17'(((j << 16) + secs / 2) / secs);
        vx.tex_t = 17'(((i << 16) + stks / 2) / stks);
    endtask

    // Grid point driver.
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || s_fire)) begin
            if (s_gap > 0) begin
                s_tvalid <= 1'b0;
                s_gap <= s_gap - 1;
            end else if (grid_points.size() > 0) begin
                s_tdata <= {6'd0, grid_points.pop_front()};
                s_tvalid <= 1'b1;
                s_gap <= s_lazy ? $urandom_range(0, 17) : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_fire) begin
                m_stall = m_lazy ? $urandom_range(0, 17) : 0;
            end
            if (m_stall > 0) begin
                m_tready <= 1'b0;
                m_stall = m_stall - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor: predict on input transfers, compare on output transfers.
    always @(posedge aclk) begin
        vertex_t want, got;
        s_fire <= aresetn && s_tvalid && s_tready;
        m_fire <= aresetn && m_tvalid && m_tready;
        cycles <= cycles + 1;
        if (aresetn && s_tvalid && s_tready) begin
            vertex_of(s_tdata[8:0], s_tdata[17:9], want);
            vertices_due.push_back(want);
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = vertex_t'(m_tdata[132:0]);
            if (vertices_due.size() == 0) begin
                $error("vertex transfer with no grid point pending");
                failed = 1;
            end else begin
                want = vertices_due.pop_front();
                if (got.pos_x !== want.pos_x) begin
                    $error("pos_x: expected %0d, got %0d", $signed(want.pos_x), $signed(got.pos_x));
                    failed = 1;
                end
                if (got.pos_y !== want.pos_y) begin
                    $error("pos_y: expected %0d, got %0d", $signed(want.pos_y), $signed(got.pos_y));
                    failed = 1;
                end
                if (got.pos_z !== want.pos_z) begin
                    $error("pos_z: expected %0d, got %0d", $signed(want.pos_z), $signed(got.pos_z));
                    failed = 1;
                end
                if (got.norm_x !== want.norm_x) begin
                    $error("norm_x: expected %0d, got %0d",
                           $signed(want.norm_x), $signed(got.norm_x));
                    failed = 1;
                end
                if (got.norm_y !== want.norm_y) begin
                    $error("norm_y: expected %0d, got %0d",
                           $signed(want.norm_y), $signed(got.norm_y));
                    failed = 1;
                end
                if (got.norm_z !== want.norm_z) begin
                    $error("norm_z: expected %0d, got %0d",
                           $signed(want.norm_z), $signed(got.norm_z));
                    failed = 1;
                end
                if (got.tex_s !== want.tex_s) begin
                    $error("tex_s: expected %0d, got %0d", want.tex_s, got.tex_s);
                    failed = 1;
                end
                if (got.tex_t !== want.tex_t) begin
                    $error("tex_t: expected %0d, got %0d", want.tex_t, got.tex_t);
                    failed = 1;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            uvsg_pkg::REG_RADIUS:  radius_q88 = value[15:0];
            uvsg_pkg::REG_SECTORS: sectors_reg = value[8:0];
            default:               stacks_reg = value[8:0];
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Waits until every grid point went out and every vertex came back.
    task automatic drain();
        @(negedge aclk);
        while (grid_points.size() > 0 || s_tvalid || vertices_due.size() > 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
    endtask

    task automatic random_points(input int count);
        logic [8:0] lim_i, lim_j;
        lim_i = (stacks_reg == 0) ? 9'd1 : stacks_reg;
        lim_j = (sectors_reg == 0) ? 9'd1 : sectors_reg;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) == 0)
                grid_points.push_back(18'($urandom));
            else
                grid_points.push_back({9'($urandom_range(0, lim_j)), 9'($urandom_range(0, lim_i))});
            if (k % 40 == 0) begin
                s_lazy = $urandom_range(0, 2) != 0;
                m_lazy = $urandom_range(0, 2) != 0;
            end
        end
    endtask

    initial begin
        logic [31:0] settings[7][3];
        settings = '{'{256, 36, 18}, '{0, 1, 1}, '{65535, 256, 256}, '{1234, 0, 0},
                     '{40000, 511, 300}, '{32768, 7, 3}, '{513, 100, 37}};
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed points under the reset settings: poles, equator, seam, saturation.
        grid_points.push_back({9'd0, 9'd0});
        grid_points.push_back({9'd0, 9'd18});
        grid_points.push_back({9'd9, 9'd9});
        grid_points.push_back({9'd36, 9'd9});
        grid_points.push_back({9'd18, 9'd0});
        grid_points.push_back({9'd37, 9'd19});
        grid_points.push_back({9'd511, 9'd511});
        grid_points.push_back({9'd256, 9'd256});
        grid_points.push_back({9'd27, 9'd4});
        grid_points.push_back({9'd170, 9'd85});
        grid_points.push_back({9'd85, 9'd170});
        drain();

        for (int p = 1; p < 7; p++) begin
            reg_write(uvsg_pkg::REG_RADIUS, settings[p][0]);
            reg_write(uvsg_pkg::REG_SECTORS, settings[p][1]);
            reg_write(uvsg_pkg::REG_STACKS, settings[p][2]);
            if (p == 2) begin
                grid_points.push_back({9'd0, 9'd0});
                grid_points.push_back({9'd256, 9'd256});
                grid_points.push_back({9'd128, 9'd128});
                grid_points.push_back({9'd64, 9'd192});
            end
            random_points(120);
            drain();
        end

        repeat (60) @(negedge aclk);
        if (!failed) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/uvsg_pkg.sv
sv/uvsg_trig.sv
sv/uv_sphere_vertex_generator.sv
tb/sv/tb_uv_sphere_vertex_generator.sv
